/* rtl/bdac_pkg.sv */
// ----------------------------------------------------------------------------
// bdac_pkg: binary to decimal ASCII shared definitions
// Widths, digit counts and the job word passed from front to back.
// ----------------------------------------------------------------------------
package bdac_pkg;

	localparam int VALUE_BITS    = 32;
	localparam int BITS_PER_STEP = 4;
	localparam int STEPS         = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PAD_BITS      = STEPS * BITS_PER_STEP;
	localparam int STEP_W        = $clog2(STEPS + 1);
	localparam int DIGITS        = ((VALUE_BITS * 1233) >> 12) + 1;
	localparam int BCD_W         = DIGITS * 4;
	localparam int CNT_W         = $clog2(DIGITS + 1);
	localparam int IDX_W         = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int CHAR_W        = 6;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [CNT_W-1:0] ndig;
	} bdac_job_t;

endpackage

/* rtl/bdac_in_if.sv */
// ----------------------------------------------------------------------------
// bdac_in_if: binary value channel
// Valid/ready channel that carries one unsigned value per word.
// ----------------------------------------------------------------------------
interface bdac_in_if import bdac_pkg::*; ();

	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);

endinterface

/* rtl/bdac_out_if.sv */
// ----------------------------------------------------------------------------
// bdac_out_if: decimal character channel
// Valid/ready channel that carries one ASCII digit and its last flag per word.
// ----------------------------------------------------------------------------
interface bdac_out_if import bdac_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);

endinterface

/* rtl/binary_to_decimal_ascii_core.sv */
// Flow: the converter works on one value at a time (an intake, 8 BCD
// steps of four bits, a hand-off that waits for room in the two-entry queue);
// the emitter loads the next job from the queue and then gives one character
// a cycle while the text sink is ready.
// Reset: arst_n clears all control state at once; no clearing pass.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core: binary to decimal ASCII converter
// Turns an unsigned value into its decimal digits, most significant first.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core import bdac_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bdac_in_if.sink    number,
	bdac_out_if.source text
);

	logic      push_valid;
	logic      push_ready;
	bdac_job_t push_job;
	logic      pop_valid;
	logic      pop_ready;
	bdac_job_t pop_job;

	bdac_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.number     (number),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	bdac_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	bdac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.text      (text)
	);

endmodule

/* rtl/bdac_front.sv */
// ----------------------------------------------------------------------------
// bdac_front: value intake and BCD conversion
// Accepts a value, converts it to BCD four bits a cycle and counts its digits.
// ----------------------------------------------------------------------------
module bdac_front import bdac_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	bdac_in_if.sink        number,
	output logic           push_valid,
	input  logic           push_ready,
	output bdac_job_t      push_job
);

	logic                busy_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [PAD_BITS-1:0] shift_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [PAD_BITS-1:0] shift_n;
	logic [BCD_W-1:0]    bcd_n;
	logic [CNT_W-1:0]    ndig;
	logic                done;

	assign number.ready = !busy_q;
	assign done         = busy_q && (cnt_q == '0);
	assign push_valid   = done;
	assign push_job     = '{bcd: bcd_q, ndig: ndig};

	always_comb begin
		bcd_n   = bcd_q;
		shift_n = shift_q;
		for (int s = 0; s < BITS_PER_STEP; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (bcd_n[d*4 +: 4] >= 4'd5) begin
					bcd_n[d*4 +: 4] = bcd_n[d*4 +: 4] + 4'd3;
				end
			end
			bcd_n   = {bcd_n[BCD_W-2:0], shift_n[PAD_BITS-1]};
			shift_n = {shift_n[PAD_BITS-2:0], 1'b0};
		end
	end

	always_comb begin
		ndig = CNT_W'(1);
		for (int d = 1; d < DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) begin
				ndig = CNT_W'(d + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (number.valid && number.ready) begin
			busy_q <= 1'b1;
			cnt_q  <= STEP_W'(STEPS);
		end else if (busy_q && cnt_q != '0) begin
			cnt_q <= cnt_q - STEP_W'(1);
		end else if (done && push_ready) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (number.valid && number.ready) begin
			shift_q <= PAD_BITS'(number.value);
			bcd_q   <= '0;
		end else if (busy_q && cnt_q != '0) begin
			shift_q <= shift_n;
			bcd_q   <= bcd_n;
		end
	end

endmodule

/* rtl/bdac_queue.sv */
// ----------------------------------------------------------------------------
// bdac_queue: job queue
// Two-entry queue that decouples the converter from the character emitter.
// ----------------------------------------------------------------------------
module bdac_queue import bdac_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  bdac_job_t push_job,
	output logic      pop_valid,
	input  logic      pop_ready,
	output bdac_job_t pop_job
);

	bdac_job_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

/* rtl/bdac_back.sv */
// ----------------------------------------------------------------------------
// bdac_back: character emitter
// Walks the BCD digits from the most significant one and registers each as ASCII.
// ----------------------------------------------------------------------------
module bdac_back import bdac_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  bdac_job_t pop_job,
	bdac_out_if.source text
);

	logic              busy_q;
	bdac_job_t         job_q;
	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              slot_free;
	logic [3:0]        digit;

	assign pop_ready      = !busy_q;
	assign slot_free      = !out_valid_q || text.ready;
	assign digit          = job_q.bcd[idx_q*4 +: 4];
	assign text.valid     = out_valid_q;
	assign text.character = char_q;
	assign text.last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (!busy_q) begin
				if (pop_valid) begin
					busy_q <= 1'b1;
					idx_q  <= IDX_W'(pop_job.ndig - CNT_W'(1));
				end
			end else if (slot_free) begin
				if (idx_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q - IDX_W'(1);
				end
			end
			if (slot_free) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && pop_valid) begin
			job_q <= pop_job;
		end
		if (busy_q && slot_free) begin
			char_q <= ASCII_ZERO + CHAR_W'(digit);
			last_q <= (idx_q == '0);
		end
	end

endmodule

/* test/tb_binary_to_decimal_ascii_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii_core: self-checking bench for the decimal converter
// The bench sends a short list of edge values first. For some of them the
// expected digit text is typed in by hand. The rest of the list, and a random
// mix of values of every digit count, are checked against a digit predictor.
// Every character word is compared in order with the oldest expected word.
// Both channels idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii_core;
	import bdac_pkg::*;

	localparam int NUM_DIRECTED = 22;
	localparam int NUM_RANDOM   = 340;
	localparam int CALM_ITEMS   = 40;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} char_word_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  typed;
		logic [79:0]           text;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;

	bdac_in_if  number_ch ();
	bdac_out_if text_ch ();

	binary_to_decimal_ascii_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number_ch),
		.text   (text_ch)
	);

	always #1 clk = ~clk;

	char_word_t    pending_chars[$];
	directed_row_t directed_rows [0:NUM_DIRECTED-1];
	bit            calm = 1'b0;
	int            mismatch_count = 0;
	int            values_sent = 0;
	int            chars_checked = 0;
	int            ten_digit_values = 0;
	int            ready_hold = 0;

	function automatic logic [VALUE_BITS-1:0] ten_power(input int k);
		logic [VALUE_BITS-1:0] p;
		p = 1;
		for (int i = 0; i < k; i++)
			p = p * 10;
		return p;
	endfunction

	function automatic void predict_digits(input logic [VALUE_BITS-1:0] v);
		logic [3:0]            digits [0:19];
		logic [VALUE_BITS-1:0] rest;
		int                    count;
		char_word_t            w;
		rest  = v;
		count = 0;
		do begin
			digits[count] = 4'(rest % 10);
			rest = rest / 10;
			count++;
		end while (rest != 0);
		if (count == 10)
			ten_digit_values++;
		for (int k = count - 1; k >= 0; k--) begin
			w.character = ASCII_ZERO + CHAR_W'(digits[k]);
			w.last      = (k == 0);
			pending_chars.push_back(w);
		end
	endfunction

	function automatic void load_typed_text(input logic [79:0] text);
		char_word_t w;
		for (int i = 9; i >= 0; i--) begin
			if (text[i*8 +: 8] != 8'd0) begin
				w.character = text[i*8 +: CHAR_W];
				w.last      = (i == 0);
				pending_chars.push_back(w);
			end
		end
		if (text[79:72] != 8'd0)
			ten_digit_values++;
	endfunction

	task automatic send_value(input logic [VALUE_BITS-1:0] v);
		if (!calm && $urandom_range(0, 3) == 0) begin
			number_ch.valid <= 1'b0;
			number_ch.value <= VALUE_BITS'($urandom());
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		number_ch.valid <= 1'b1;
		number_ch.value <= v;
		@(posedge clk);
		while (!number_ch.ready) @(posedge clk);
		values_sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (ready_hold > 0) begin
				ready_hold     <= ready_hold - 1;
				text_ch.ready  <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				ready_hold     <= $urandom_range(1, 17) - 1;
				text_ch.ready  <= 1'b0;
			end else begin
				text_ch.ready  <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		char_word_t want;
		if (arst_n && text_ch.valid && text_ch.ready) begin
			chars_checked++;
			if (pending_chars.size() == 0) begin
				$error("unexpected character word: character=%0d last=%0b",
					text_ch.character, text_ch.last);
				mismatch_count++;
			end else begin
				want = pending_chars.pop_front();
				if (text_ch.character !== want.character) begin
					$error("character: expected %0d, actual %0d",
						want.character, text_ch.character);
					mismatch_count++;
				end
				if (text_ch.last !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, text_ch.last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [VALUE_BITS-1:0] v;
		logic [VALUE_BITS-1:0] lo;
		logic [VALUE_BITS-1:0] hi;
		int                    n;
		int                    k;
		arst_n          = 1'b0;
		number_ch.valid = 1'b0;
		number_ch.value = '0;
		text_ch.ready   = 1'b0;

		directed_rows = '{
			'{32'd0,          1'b1, "0"},
			'{32'd1,          1'b1, "1"},
			'{32'd9,          1'b1, "9"},
			'{32'd10,         1'b1, "10"},
			'{32'd99,         1'b1, "99"},
			'{32'd100,        1'b1, "100"},
			'{32'd255,        1'b0, 80'd0},
			'{32'd1000,       1'b1, "1000"},
			'{32'd65535,      1'b0, 80'd0},
			'{32'd999999999,  1'b1, "999999999"},
			'{32'd1000000000, 1'b1, "1000000000"},
			'{32'hFFFFFFFF,   1'b1, "4294967295"},
			'{32'hFFFFFFFE,   1'b0, 80'd0},
			'{32'h80000000,   1'b1, "2147483648"},
			'{32'h7FFFFFFF,   1'b0, 80'd0},
			'{32'hAAAAAAAA,   1'b0, 80'd0},
			'{32'h55555555,   1'b0, 80'd0},
			'{32'd1234567890, 1'b1, "1234567890"},
			'{32'd4000000000, 1'b0, 80'd0},
			'{32'd3999999999, 1'b0, 80'd0},
			'{32'd100000,     1'b0, 80'd0},
			'{32'd9999999,    1'b0, 80'd0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_value(directed_rows[i].value);
			if (directed_rows[i].typed)
				load_typed_text(directed_rows[i].text);
			else
				predict_digits(directed_rows[i].value);
		end

		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i >= NUM_RANDOM - CALM_ITEMS)
				calm = 1'b1;
			case ($urandom_range(0, 9))
				0: v = VALUE_BITS'($urandom());
				1: begin
					k = $urandom_range(0, 9);
					v = ten_power(k) + $urandom_range(0, 2) - 1;
				end
				2: v = 32'hFFFFFFFF - $urandom_range(0, 15);
				3: v = '0;
				default: begin
					n  = $urandom_range(1, 10);
					lo = (n == 1) ? '0 : ten_power(n - 1);
					hi = (n == 10) ? 32'hFFFFFFFF : ten_power(n) - 1;
					v  = $urandom_range(hi, lo);
				end
			endcase
			send_value(v);
			predict_digits(v);
		end
		number_ch.valid <= 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d values (%0d of ten digits) into %0d checked characters,",
			values_sent, ten_digit_values, chars_checked);
		$display("with random idle bursts on both channels and a calm final stretch.");
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* binary_to_decimal_ascii_core.f */
rtl/bdac_pkg.sv
rtl/bdac_in_if.sv
rtl/bdac_out_if.sv
rtl/bdac_front.sv
rtl/bdac_queue.sv
rtl/bdac_back.sv
rtl/binary_to_decimal_ascii_core.sv
test/tb_binary_to_decimal_ascii_core.sv
